[design/pidpa_pkg.sv]
// Shared types and constants for the identifier pool allocator.
`default_nettype none

package pidpa_pkg;

   // Bitmap word geometry: the in-use map is kept as 64-bit words
   localparam int WORD_W = 64;
   localparam int BIT_W  = 6;

   // Pool length arithmetic reaches 65536 (room above base 0), so it needs 17 bits
   localparam int LEN_W  = 17;

   localparam int DEF_POOL_SIZE = 8192;

   // Register reset values (pool 300 .. 5000)
   localparam logic [15:0] BASE_PID_RST  = 16'd300;
   localparam logic [13:0] PID_COUNT_RST = 14'd4701;

   typedef enum logic [0:0] {
      CSR_BASE_PID  = 1'b0,
      CSR_PID_COUNT = 1'b1
   } csr_idx_type;

   typedef enum logic [0:0] {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      STS_ALLOCATED = 3'd0,
      STS_FULL      = 3'd1,
      STS_RELEASED  = 3'd2,
      STS_RANGE     = 3'd3,
      STS_NOT_ALLOC = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_HINT_CHK,
      FSM_SCAN,
      FSM_REL_CHK
   } fsm_type;

   // Result of examining one bitmap word
   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] bit_idx;
      logic             last;
   } scan_res_type;

endpackage

`default_nettype wire

[design/pidpa_map_ram.sv]
// In-use bitmap memory: one write port, one registered read port.
`default_nettype none

module pidpa_map_ram #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [AW-1:0]               wr_addr,
   input  wire logic [pidpa_pkg::WORD_W-1:0] wr_data,
   input  wire logic [AW-1:0]               rd_addr,
   output logic      [pidpa_pkg::WORD_W-1:0] rd_data
);

   logic [pidpa_pkg::WORD_W-1:0] mem_ff [DEPTH];
   logic [pidpa_pkg::WORD_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/pidpa_word_scan.sv]
// Finds the lowest free in-pool bit of one bitmap word.
`default_nettype none

module pidpa_word_scan (
   input  wire logic [pidpa_pkg::WORD_W-1:0] word_data,
   input  wire logic [pidpa_pkg::LEN_W-1:0]  word_start,
   input  wire logic [pidpa_pkg::LEN_W-1:0]  pool_len,
   output pidpa_pkg::scan_res_type           scan_res
);

   logic [pidpa_pkg::LEN_W-1:0]  remain;
   logic [pidpa_pkg::LEN_W-1:0]  word_end;
   logic [pidpa_pkg::WORD_W-1:0] free_bits;

   // bits at or beyond the pool length count as taken
   always_comb begin
      remain = (pool_len > word_start) ? (pool_len - word_start) : '0;
      for (int b = 0; b < pidpa_pkg::WORD_W; b++) begin
         free_bits[b] = !word_data[b] && (remain > pidpa_pkg::LEN_W'(b));
      end
   end

   // priority pick, lowest index wins
   always_comb begin
      word_end = word_start + pidpa_pkg::LEN_W'(pidpa_pkg::WORD_W);
      scan_res.found   = 1'b0;
      scan_res.bit_idx = '0;
      scan_res.last    = (word_end >= pool_len);
      for (int b = pidpa_pkg::WORD_W - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            scan_res.found   = 1'b1;
            scan_res.bit_idx = pidpa_pkg::BIT_W'(b);
         end
      end
   end

endmodule

`default_nettype wire

[design/pid_pool_allocator_core.sv]
// Top level: identifier pool allocator with bitmap store and word-scan sequencer.
// Release and hint hit answer via the check state and the response register; range
// errors answer from idle. A hint miss scans the map one 64-bit word per cycle from
// word 0, up to ceil(pool length / 64) words; the single map read port sets this rate.
// Reset clears all (POOL_SIZE+63)/64 map words, busy high meanwhile; config is
// taken as ever. The result strobe rsp_valid lasts one cycle; the receiver cannot stall.
`default_nettype none

module pid_pool_allocator_core #(
   parameter int POOL_SIZE = pidpa_pkg::DEF_POOL_SIZE
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request word
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_operation,
   input  wire logic [12:0] req_hint_offset,
   input  wire logic [15:0] req_pid,
   // response word
   output logic             rsp_valid,
   output logic [15:0]      rsp_result_pid,
   output logic [2:0]       rsp_status,
   // register writes
   input  wire logic        csr_wr_en,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_wr_data
);

   localparam int MAP_WORDS = (POOL_SIZE + pidpa_pkg::WORD_W - 1) / pidpa_pkg::WORD_W;
   localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(MAP_WORDS - 1);

   localparam int LW = pidpa_pkg::LEN_W;
   localparam int BW = pidpa_pkg::BIT_W;
   localparam int WW = pidpa_pkg::WORD_W;

   pidpa_pkg::fsm_type state_ff, state_in;

   logic [15:0]        base_pid_ff;
   logic [13:0]        pid_count_ff;
   logic [12:0]        hint_ff, hint_in;
   logic [15:0]        rel_off_ff, rel_off_in;
   logic [WORD_AW-1:0] clear_idx_ff, clear_idx_in;
   logic [WORD_AW-1:0] scan_idx_ff, scan_idx_in;
   logic [WORD_AW-1:0] chk_idx_ff, chk_idx_in;
   logic               chk_valid_ff, chk_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_pid_ff, rsp_pid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;

   logic [LW-1:0]      room;
   logic [LW-1:0]      pool_len;
   logic [15:0]        req_off;
   logic               req_out_range;
   logic [15:0]        scan_off;

   logic               wr_en;
   logic [WORD_AW-1:0] wr_addr;
   logic [WW-1:0]      wr_data;
   logic [WORD_AW-1:0] rd_addr;
   logic [WW-1:0]      rd_data;

   pidpa_pkg::scan_res_type scan_res;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_pid_ff  <= pidpa_pkg::BASE_PID_RST;
         pid_count_ff <= pidpa_pkg::PID_COUNT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            pidpa_pkg::CSR_BASE_PID:  base_pid_ff  <= csr_wr_data;
            pidpa_pkg::CSR_PID_COUNT: pid_count_ff <= csr_wr_data[13:0];
            default: ;
         endcase
      end
   end

   // effective pool length: min(count, POOL_SIZE, 65536 - base)
   always_comb begin
      room     = LW'(17'h10000) - {1'b0, base_pid_ff};
      pool_len = LW'(pid_count_ff);
      if (pool_len > LW'(POOL_SIZE)) begin
         pool_len = LW'(POOL_SIZE);
      end
      if (pool_len > room) begin
         pool_len = room;
      end
   end

   // release range check
   assign req_off       = req_pid - base_pid_ff;
   assign req_out_range = (req_pid < base_pid_ff) || (LW'(req_off) >= pool_len);

   // word examine unit, shared by every scan step
   pidpa_word_scan u_word_scan (
      .word_data  (rd_data),
      .word_start (LW'(chk_idx_ff) << BW),
      .pool_len   (pool_len),
      .scan_res   (scan_res)
   );

   assign scan_off = (16'(chk_idx_ff) << BW) | 16'(scan_res.bit_idx);

   pidpa_map_ram #(
      .DEPTH (MAP_WORDS),
      .AW    (WORD_AW)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // state register and control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pidpa_pkg::FSM_CLEAR;
         clear_idx_ff <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_idx_ff <= clear_idx_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and index registers
   always_ff @(posedge clock) begin
      hint_ff       <= hint_in;
      rel_off_ff    <= rel_off_in;
      scan_idx_ff   <= scan_idx_in;
      chk_idx_ff    <= chk_idx_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_status_ff <= rsp_status_in;
   end

   // sequencer: next state, map access and response
   always_comb begin
      state_in      = state_ff;
      hint_in       = hint_ff;
      rel_off_in    = rel_off_ff;
      clear_idx_in  = clear_idx_ff;
      scan_idx_in   = scan_idx_ff;
      chk_idx_in    = scan_idx_ff;
      chk_valid_in  = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_pid_in    = rsp_pid_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = scan_idx_ff;
      wr_en         = 1'b0;
      wr_addr       = chk_idx_ff;
      wr_data       = rd_data;

      case (state_ff)
         // sweep zeros through the map after reset
         pidpa_pkg::FSM_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clear_idx_ff;
            wr_data = '0;
            if (clear_idx_ff == LAST_WORD) begin
               state_in = pidpa_pkg::FSM_IDLE;
            end else begin
               clear_idx_in = clear_idx_ff + WORD_AW'(1);
            end
         end

         pidpa_pkg::FSM_IDLE: begin
            if (start) begin
               hint_in    = req_hint_offset;
               rel_off_in = req_off;
               if (req_operation == pidpa_pkg::OP_ALLOC) begin
                  if (LW'(req_hint_offset) < pool_len) begin
                     rd_addr  = WORD_AW'(req_hint_offset >> BW);
                     state_in = pidpa_pkg::FSM_HINT_CHK;
                  end else begin
                     scan_idx_in = '0;
                     state_in    = pidpa_pkg::FSM_SCAN;
                  end
               end else if (req_out_range) begin
                  rsp_valid_in  = 1'b1;
                  rsp_pid_in    = '0;
                  rsp_status_in = pidpa_pkg::STS_RANGE;
               end else begin
                  rd_addr  = WORD_AW'(req_off >> BW);
                  state_in = pidpa_pkg::FSM_REL_CHK;
               end
            end
         end

         // preferred entry: take it if free, else fall back to the scan
         pidpa_pkg::FSM_HINT_CHK: begin
            if (!rd_data[hint_ff[BW-1:0]]) begin
               wr_en         = 1'b1;
               wr_addr       = WORD_AW'(hint_ff >> BW);
               wr_data       = rd_data | (WW'(1) << hint_ff[BW-1:0]);
               rsp_valid_in  = 1'b1;
               rsp_pid_in    = base_pid_ff + 16'(hint_ff);
               rsp_status_in = pidpa_pkg::STS_ALLOCATED;
               state_in      = pidpa_pkg::FSM_IDLE;
            end else begin
               scan_idx_in = '0;
               state_in    = pidpa_pkg::FSM_SCAN;
            end
         end

         // one word read per cycle, the word read last cycle is examined
         pidpa_pkg::FSM_SCAN: begin
            rd_addr      = scan_idx_ff;
            scan_idx_in  = scan_idx_ff + WORD_AW'(1);
            chk_valid_in = 1'b1;
            if (chk_valid_ff) begin
               if (scan_res.found) begin
                  wr_en         = 1'b1;
                  wr_addr       = chk_idx_ff;
                  wr_data       = rd_data | (WW'(1) << scan_res.bit_idx);
                  rsp_valid_in  = 1'b1;
                  rsp_pid_in    = base_pid_ff + scan_off;
                  rsp_status_in = pidpa_pkg::STS_ALLOCATED;
                  chk_valid_in  = 1'b0;
                  state_in      = pidpa_pkg::FSM_IDLE;
               end else if (scan_res.last) begin
                  rsp_valid_in  = 1'b1;
                  rsp_pid_in    = '0;
                  rsp_status_in = pidpa_pkg::STS_FULL;
                  chk_valid_in  = 1'b0;
                  state_in      = pidpa_pkg::FSM_IDLE;
               end
            end
         end

         // release: clear the bit if it was set
         pidpa_pkg::FSM_REL_CHK: begin
            rsp_valid_in = 1'b1;
            state_in     = pidpa_pkg::FSM_IDLE;
            if (rd_data[rel_off_ff[BW-1:0]]) begin
               wr_en         = 1'b1;
               wr_addr       = WORD_AW'(rel_off_ff >> BW);
               wr_data       = rd_data & ~(WW'(1) << rel_off_ff[BW-1:0]);
               rsp_pid_in    = base_pid_ff + rel_off_ff;
               rsp_status_in = pidpa_pkg::STS_RELEASED;
            end else begin
               rsp_pid_in    = '0;
               rsp_status_in = pidpa_pkg::STS_NOT_ALLOC;
            end
         end

         default: begin
            state_in = pidpa_pkg::FSM_IDLE;
         end
      endcase
   end

   assign busy           = (state_ff != pidpa_pkg::FSM_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result_pid = rsp_pid_ff;
   assign rsp_status     = rsp_status_ff;

   // every accepted word either answers next cycle or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted request neither answered nor in progress");

   // a response strobe is only seen while the block is idle
   a_rsp_in_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == pidpa_pkg::FSM_IDLE))
      else $error("response strobe outside idle");

   // the scan writes only a word it has actually examined
   a_scan_write_checked: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == pidpa_pkg::FSM_SCAN) && wr_en) |-> chk_valid_ff)
      else $error("scan wrote map without a checked word");

   // failures never carry an identifier
   a_fail_zero_pid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == pidpa_pkg::STS_FULL
                     || rsp_status == pidpa_pkg::STS_RANGE
                     || rsp_status == pidpa_pkg::STS_NOT_ALLOC))
      |-> (rsp_result_pid == 16'd0))
      else $error("failure response with nonzero identifier");

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the identifier pool allocator core.
`default_nettype none

module tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL_ENTRIES = pidpa_pkg::DEF_POOL_SIZE;
   localparam int SCAN_SETTLE  = 140;    // worst scan visits all 128 map words

   typedef enum logic [0:0] {
      ROW_REQ,
      ROW_CFG
   } row_kind_type;

   typedef struct packed {
      logic [15:0]           pid;
      pidpa_pkg::status_type sts;
   } answer_type;

   // One line of the directed plan; a CFG line carries base in pid, count data in cnt
   typedef struct packed {
      row_kind_type          kind;
      pidpa_pkg::op_type     op;
      logic [12:0]           hint;
      logic [15:0]           pid;
      logic [15:0]           cnt;
      logic                  typed;
      logic [15:0]           want_pid;
      pidpa_pkg::status_type want_sts;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_operation = 1'b0;
   logic [12:0] req_hint_offset = '0;
   logic [15:0] req_pid = '0;
   logic        rsp_valid;
   logic [15:0] rsp_result_pid;
   logic [2:0]  rsp_status;
   logic        csr_wr_en = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [15:0] csr_wr_data = '0;

   // Shadow of the allocator: in-use bits and register copies
   bit          owned_map [0:POOL_ENTRIES-1];
   logic [15:0] base_q = pidpa_pkg::BASE_PID_RST;
   logic [13:0] count_q = pidpa_pkg::PID_COUNT_RST;

   answer_type  pending_answers [$];
   int          live_offsets [$];
   int          mismatch_count = 0;
   bit          idle_on = 1'b1;

   // Directed plan, starting from the reset pool 300 .. 5000
   plan_row_type plan [0:26] = '{
      '{ROW_REQ, pidpa_pkg::OP_ALLOC,   13'd0,    16'hFFFF, 16'd0,
        1'b1, 16'd300,  pidpa_pkg::STS_ALLOCATED},
      '{ROW_REQ, pidpa_pkg::OP_ALLOC,   13'd4700, 16'd0,    16'd0,
        1'b1, 16'd5000, pidpa_pkg::STS_ALLOCATED},
      '{ROW_REQ, pidpa_pkg::OP_ALLOC,   13'd4701, 16'd0,    16'd0,
        1'b1, 16'd301,  pidpa_pkg::STS_ALLOCATED},
      '{ROW_REQ, pidpa_pkg::OP_ALLOC,   13'd8191, 16'd0,    16'd0,
        1'b1, 16'd302,  pidpa_pkg::STS_ALLOCATED},
      '{ROW_REQ, pidpa_pkg::OP_ALLOC,   13'd0,    16'd0,    16'd0,
        1'b1, 16'd303,  pidpa_pkg::STS_ALLOCATED},
      '{ROW_REQ, pidpa_pkg::OP_RELEASE, 13'd8191, 16'd299,  16'd0,
        1'b1, 16'd0,    pidpa_pkg::STS_RANGE},
      '{ROW_REQ, pidpa_pkg::OP_RELEASE, 13'd0,    16'd5001, 16'd0,
        1'b1, 16'd0,    pidpa_pkg::STS_RANGE},
      '{ROW_REQ, pidpa_pkg::OP_RELEASE, 13'd0,    16'd0,    16'd0,
        1'b1, 16'd0,    pidpa_pkg::STS_RANGE},
      '{ROW_REQ, pidpa_pkg::OP_RELEASE, 13'd0,    16'hFFFF, 16'd0,
        1'b1, 16'd0,    pidpa_pkg::STS_RANGE},
      '{ROW_REQ, pidpa_pkg::OP_RELEASE, 13'd0,    16'd300,  16'd0,
        1'b1, 16'd300,  pidpa_pkg::STS_RELEASED},
      '{ROW_REQ, pidpa_pkg::OP_RELEASE, 13'd0,    16'd300,  16'd0,
        1'b1, 16'd0,    pidpa_pkg::STS_NOT_ALLOC},
      '{ROW_REQ, pidpa_pkg::OP_RELEASE, 13'd0,    16'd5000, 16'd0,
        1'b1, 16'd5000, pidpa_pkg::STS_RELEASED},
      '{ROW_REQ, pidpa_pkg::OP_ALLOC,   13'd0,    16'd0,    16'd0,
        1'b1, 16'd300,  pidpa_pkg::STS_ALLOCATED},
      // pool clipped at the top of the identifier space: six entries
      '{ROW_CFG, pidpa_pkg::OP_ALLOC,   13'd0,    16'd65530, 16'hC010,
        1'b0, 16'd0,    pidpa_pkg::STS_ALLOCATED},
      '{ROW_REQ, pidpa_pkg::OP_ALLOC,   13'd5,    16'd0,    16'd0,
        1'b0, 16'd0,    pidpa_pkg::STS_ALLOCATED},
      '{ROW_REQ, pidpa_pkg::OP_ALLOC,   13'd0,    16'd0,    16'd0,
        1'b0, 16'd0,    pidpa_pkg::STS_ALLOCATED},
      '{ROW_REQ, pidpa_pkg::OP_ALLOC,   13'd13,   16'd0,    16'd0,
        1'b0, 16'd0,    pidpa_pkg::STS_ALLOCATED},
      '{ROW_REQ, pidpa_pkg::OP_RELEASE, 13'd0,    16'd65530, 16'd0,
        1'b0, 16'd0,    pidpa_pkg::STS_ALLOCATED},
      // highest base with the largest count
      '{ROW_CFG, pidpa_pkg::OP_ALLOC,   13'd0,    16'd57343, 16'h2000,
        1'b0, 16'd0,    pidpa_pkg::STS_ALLOCATED},
      '{ROW_REQ, pidpa_pkg::OP_ALLOC,   13'd8191, 16'd0,    16'd0,
        1'b0, 16'd0,    pidpa_pkg::STS_ALLOCATED},
      '{ROW_REQ, pidpa_pkg::OP_RELEASE, 13'd0,    16'hFFFF, 16'd0,
        1'b0, 16'd0,    pidpa_pkg::STS_ALLOCATED},
      // count field reads zero: empty pool
      '{ROW_CFG, pidpa_pkg::OP_ALLOC,   13'd0,    16'd0,    16'h4000,
        1'b0, 16'd0,    pidpa_pkg::STS_ALLOCATED},
      '{ROW_REQ, pidpa_pkg::OP_ALLOC,   13'd0,    16'd0,    16'd0,
        1'b1, 16'd0,    pidpa_pkg::STS_FULL},
      '{ROW_REQ, pidpa_pkg::OP_RELEASE, 13'd0,    16'd0,    16'd0,
        1'b1, 16'd0,    pidpa_pkg::STS_RANGE},
      // single-entry pool
      '{ROW_CFG, pidpa_pkg::OP_ALLOC,   13'd0,    16'd0,    16'd1,
        1'b0, 16'd0,    pidpa_pkg::STS_ALLOCATED},
      '{ROW_REQ, pidpa_pkg::OP_ALLOC,   13'd1,    16'd0,    16'd0,
        1'b0, 16'd0,    pidpa_pkg::STS_ALLOCATED},
      '{ROW_REQ, pidpa_pkg::OP_ALLOC,   13'd0,    16'd0,    16'd0,
        1'b0, 16'd0,    pidpa_pkg::STS_ALLOCATED}
   };

   pid_pool_allocator_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_hint_offset (req_hint_offset),
      .req_pid         (req_pid),
      .rsp_valid       (rsp_valid),
      .rsp_result_pid  (rsp_result_pid),
      .rsp_status      (rsp_status),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Usable entries: count, capped by the map and by the top of the identifier space
   function automatic int pool_len();
      int n;
      n = count_q;
      if (n > POOL_ENTRIES) n = POOL_ENTRIES;
      if (n > 65536 - int'(base_q)) n = 65536 - int'(base_q);
      return n;
   endfunction

   // Work out the answer to one request word and update the shadow map
   function automatic answer_type predict_answer(input pidpa_pkg::op_type op,
                                                 input logic [12:0] hint,
                                                 input logic [15:0] pid);
      answer_type a;
      int n;
      int off;
      int i;
      int p;
      n = pool_len();
      a.pid = '0;
      if (op == pidpa_pkg::OP_ALLOC) begin
         off = n;
         if (int'(hint) < n && !owned_map[hint]) begin
            off = hint;
         end else begin
            i = 0;
            while (i < n && off == n) begin
               if (!owned_map[i]) off = i;
               i++;
            end
         end
         if (off < n) begin
            owned_map[off] = 1'b1;
            a.pid = 16'(int'(base_q) + off);
            a.sts = pidpa_pkg::STS_ALLOCATED;
         end else begin
            a.sts = pidpa_pkg::STS_FULL;
         end
      end else begin
         p = pid;
         if (p < int'(base_q) || p - int'(base_q) >= n) begin
            a.sts = pidpa_pkg::STS_RANGE;
         end else if (owned_map[p - int'(base_q)]) begin
            owned_map[p - int'(base_q)] = 1'b0;
            a.pid = pid;
            a.sts = pidpa_pkg::STS_RELEASED;
         end else begin
            a.sts = pidpa_pkg::STS_NOT_ALLOC;
         end
      end
      return a;
   endfunction

   // Offer one request word, wait for acceptance, queue its answer
   task automatic send_word(input pidpa_pkg::op_type op, input logic [12:0] hint,
                            input logic [15:0] pid,
                            input logic typed, input answer_type given);
      answer_type a;
      if (idle_on && $urandom_range(99) < 6) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
      start           <= 1'b1;
      req_operation   <= op;
      req_hint_offset <= hint;
      req_pid         <= pid;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      a = predict_answer(op, hint, pid);
      if (a.sts == pidpa_pkg::STS_ALLOCATED) begin
         live_offsets.push_back(int'(16'(a.pid - base_q)));
      end
      pending_answers.push_back(typed ? given : a);
   endtask

   // Hold off until every answer is in, then let the block settle
   task automatic wait_quiet(input int settle);
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Write both pool registers back to back
   task automatic write_pool(input logic [15:0] base, input logic [15:0] cnt);
      csr_wr_en   <= 1'b1;
      csr_index   <= pidpa_pkg::CSR_BASE_PID;
      csr_wr_data <= base;
      @(posedge clock);
      csr_index   <= pidpa_pkg::CSR_PID_COUNT;
      csr_wr_data <= cnt;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      base_q  = base;
      count_q = cnt[13:0];
   endtask

   // Answer checker: every strobed word must match the oldest expectation
   always @(posedge clock) begin : check_answer
      answer_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (pending_answers.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected answer, expected none, got pid %0d status %0d",
                     $time, rsp_result_pid, rsp_status);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_valid !== 1'b1) begin
               mismatch_count++;
               $display("%0t: strobe expected 1, got %b", $time, rsp_valid);
            end
            if (rsp_result_pid !== want.pid) begin
               mismatch_count++;
               $display("%0t: result_pid expected %0d, got %0d",
                        $time, want.pid, rsp_result_pid);
            end
            if (rsp_status !== want.sts) begin
               mismatch_count++;
               $display("%0t: status expected %0d, got %0d", $time, want.sts, rsp_status);
            end
         end
      end
   end

   // Stimulus: directed plan, then random phases over several pool settings
   initial begin
      int n;
      int sel;
      int idx;
      int cnt;
      logic [15:0]       base;
      pidpa_pkg::op_type op;
      logic [12:0]       hint;
      logic [15:0]       pid;
      answer_type        none;

      none = '0;
      foreach (owned_map[i]) owned_map[i] = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         if (plan[r].kind == ROW_CFG) begin
            wait_quiet(8);
            write_pool(plan[r].pid, plan[r].cnt);
         end else begin
            send_word(plan[r].op, plan[r].hint, plan[r].pid, plan[r].typed,
                      '{pid: plan[r].want_pid, sts: plan[r].want_sts});
         end
      end

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin base = 16'($urandom_range(57343)); cnt = $urandom_range(1, 64);   end
            1: begin
               base = pidpa_pkg::BASE_PID_RST;
               cnt  = pidpa_pkg::PID_COUNT_RST;
            end
            2: begin base = 16'($urandom_range(57343)); cnt = $urandom_range(1, 16);   end
            3: begin base = 16'd57343;                  cnt = POOL_ENTRIES;            end
            4: begin base = 16'($urandom_range(57343)); cnt = $urandom_range(1, 8192); end
            default: begin base = 16'd0;                cnt = $urandom_range(1, 100);  end
         endcase
         wait_quiet(8);
         write_pool(base, {2'($urandom_range(3)), 14'(cnt)});
         // one long stretch with no sender gaps
         idle_on = (ph != 2);
         for (int k = 0; k < 100; k++) begin
            n    = pool_len();
            sel  = $urandom_range(99);
            hint = 13'($urandom_range(8191));
            pid  = 16'($urandom_range(65535));
            op   = pidpa_pkg::OP_RELEASE;
            if (sel < 45) begin
               op = pidpa_pkg::OP_ALLOC;
               if (n > 0 && $urandom_range(99) < 70) hint = 13'($urandom_range(n - 1));
            end else if (sel < 80) begin
               if (live_offsets.size() > 0) begin
                  idx = $urandom_range(live_offsets.size() - 1);
                  pid = 16'(int'(base_q) + live_offsets[idx]);
                  live_offsets.delete(idx);
               end else if (n > 0) begin
                  pid = 16'(int'(base_q) + $urandom_range(n - 1));
               end
            end else if (sel < 90) begin
               if (n > 0) pid = 16'(int'(base_q) + $urandom_range(n - 1));
            end else begin
               op = pidpa_pkg::op_type'($urandom_range(1));
            end
            send_word(op, hint, pid, 1'b0, none);
            if (ph == 1 && k == 50) wait_quiet(1);
         end
      end

      wait_quiet(SCAN_SETTLE);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
